// ===== rtl/llos_pkg.sv =====
package llos_pkg;

  localparam int unsigned LABEL_W     = 16;
  localparam int unsigned ATLAS_W     = 4;
  localparam int unsigned AGREE_W     = 3;
  localparam int unsigned NM1_W       = 3;
  localparam int unsigned MAX_ATLASES = 8;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SUM_W       = CNT_W + 3;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned RATIO_W     = FRAC_BITS + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(FRAC_BITS + 1);

  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = LABEL_W;

  localparam logic [CFG_IDX_W-1:0] REG_LABEL_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COUNT = 1'b1;

  localparam logic [ATLAS_W-1:0] ATLAS_RESET = ATLAS_W'(MAX_ATLASES);
  localparam logic [ATLAS_W-1:0] ATLAS_MIN   = ATLAS_W'(2);
  localparam logic [NM1_W-1:0]   NM1_MIN     = NM1_W'(1);
  localparam logic [NM1_W-1:0]   NM1_MAX     = NM1_W'(MAX_ATLASES - 1);
  localparam logic [RATIO_W-1:0] ONE_Q16     = RATIO_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic               is_held;
    logic               is_major;
    logic [AGREE_W-1:0] agree;
    logic [NM1_W-1:0]   nm1;
    logic               last;
  } voxel_t;

endpackage

// ===== rtl/llos_if.sv =====
interface llos_in_if;
  logic                             valid;
  logic                             ready;
  logic [llos_pkg::LABEL_W-1:0]     held_label;
  logic [llos_pkg::AGREE_W-1:0]     agree_count;
  logic                             last_voxel;

  modport source (output valid, held_label, agree_count, last_voxel, input ready);
  modport sink   (input valid, held_label, agree_count, last_voxel, output ready);
endinterface

interface llos_out_if;
  logic                             valid;
  logic                             ready;
  logic [llos_pkg::RATIO_W-1:0]     soft_ratio;
  logic [llos_pkg::RATIO_W-1:0]     majority_ratio;
  logic                             soft_empty;
  logic                             majority_empty;

  modport source (output valid, soft_ratio, majority_ratio, soft_empty, majority_empty,
                  input ready);
  modport sink   (input valid, soft_ratio, majority_ratio, soft_empty, majority_empty,
                  output ready);
endinterface

// ===== rtl/llos_front.sv =====
module llos_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  llos_in_if.sink                            vox_i,
  input  logic                               cfg_we_i,
  input  logic [llos_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [llos_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output llos_pkg::voxel_t                   q_data_o
);

  logic [llos_pkg::LABEL_W-1:0] label_q;
  logic [llos_pkg::ATLAS_W-1:0] atlas_q;
  logic [llos_pkg::NM1_W-1:0]   nm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q <= '0;
      atlas_q <= llos_pkg::ATLAS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        llos_pkg::REG_LABEL_VALUE: label_q <= cfg_wdata_i[llos_pkg::LABEL_W-1:0];
        llos_pkg::REG_ATLAS_COUNT: atlas_q <= cfg_wdata_i[llos_pkg::ATLAS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp N to its legal range, then take N-1
  always_comb begin
    priority if (atlas_q < llos_pkg::ATLAS_MIN) begin
      nm1 = llos_pkg::NM1_MIN;
    end else if (atlas_q > llos_pkg::ATLAS_W'(llos_pkg::MAX_ATLASES)) begin
      nm1 = llos_pkg::NM1_MAX;
    end else begin
      nm1 = llos_pkg::NM1_W'(atlas_q - llos_pkg::ATLAS_W'(1));
    end
  end

  assign vox_i.ready = !q_full_i;
  assign q_push_o    = vox_i.valid && !q_full_i;

  always_comb begin
    q_data_o.is_held  = (vox_i.held_label == label_q);
    q_data_o.is_major = ({1'b0, vox_i.agree_count, 1'b0} > {2'b00, nm1});
    q_data_o.agree    = vox_i.agree_count;
    q_data_o.nm1      = nm1;
    q_data_o.last     = vox_i.last_voxel;
  end

endmodule

// ===== rtl/llos_fifo.sv =====
module llos_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  llos_pkg::voxel_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output llos_pkg::voxel_t pop_data_o
);

  llos_pkg::voxel_t                mem_q [llos_pkg::QDEPTH];
  logic [llos_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [llos_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o     = (cnt_q == llos_pkg::QCNT_W'(llos_pkg::QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == llos_pkg::QPTR_W'(llos_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == llos_pkg::QPTR_W'(llos_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/llos_div.sv =====
module llos_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [llos_pkg::SUM_W-1:0]      num_i,
  input  logic [llos_pkg::SUM_W-1:0]      den_i,
  output logic                            busy_o,
  output logic [llos_pkg::RATIO_W-1:0]    quo_o
);

  logic [llos_pkg::SUM_W-1:0]     rem_q, den_q;
  logic [llos_pkg::RATIO_W-1:0]   quo_q;
  logic [llos_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [llos_pkg::SUM_W:0]       rem_sh;
  logic [llos_pkg::SUM_W:0]       rem_sub;
  logic                           take;

  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = (rem_sh >= {1'b0, den_q});
  assign busy_o  = (cnt_q != '0);
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= (num_i >= den_i) ? llos_pkg::ONE_Q16 : '0;
    end else if (busy_o) begin
      rem_q <= take ? rem_sub[llos_pkg::SUM_W-1:0] : rem_sh[llos_pkg::SUM_W-1:0];
      quo_q <= {quo_q[llos_pkg::RATIO_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= (num_i >= den_i) ? '0 : llos_pkg::DIV_CNT_W'(llos_pkg::FRAC_BITS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/llos_back.sv =====
module llos_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  llos_pkg::voxel_t q_data_i,
  output logic             q_pop_o,
  llos_out_if.source       res_o
);

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [llos_pkg::SUM_W-1:0]     agree_q, agree_d;
  logic [llos_pkg::CNT_W-1:0]     held_q, held_d;
  logic [llos_pkg::CNT_W-1:0]     inter_q, inter_d;
  logic [llos_pkg::CNT_W-1:0]     union_q, union_d;
  logic [llos_pkg::NM1_W-1:0]     nm1_q, nm1_d;
  logic [llos_pkg::SUM_W-1:0]     den_soft_q;
  logic                           soft_empty_q, maj_empty_q;
  logic                           out_valid_q, out_valid_d;
  logic                           load_out;
  logic                           div_start;
  logic [llos_pkg::SUM_W:0]       agree_add;
  logic                           soft_busy, maj_busy;
  logic [llos_pkg::RATIO_W-1:0]   soft_quo, maj_quo;
  logic [llos_pkg::RATIO_W-1:0]   soft_ratio_q, maj_ratio_q;
  logic                           soft_flag_q, maj_flag_q;

  assign agree_add = {1'b0, agree_q} + llos_pkg::SUM_W'(q_data_i.agree);
  assign q_pop_o   = (state_q == ST_ACC) && !q_empty_i;
  assign div_start = (state_q == ST_START);
  assign load_out  = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    agree_d = agree_q;
    held_d  = held_q;
    inter_d = inter_q;
    union_d = union_q;
    nm1_d   = nm1_q;
    unique case (state_q)
      ST_ACC: begin
        if (q_pop_o) begin
          if (q_data_i.is_held) begin
            agree_d = agree_add[llos_pkg::SUM_W] ? '1 : agree_add[llos_pkg::SUM_W-1:0];
            held_d  = (&held_q) ? held_q : held_q + 1'b1;
          end
          if (q_data_i.is_held && q_data_i.is_major) begin
            inter_d = (&inter_q) ? inter_q : inter_q + 1'b1;
          end
          if (q_data_i.is_held || q_data_i.is_major) begin
            union_d = (&union_q) ? union_q : union_q + 1'b1;
          end
          if (q_data_i.last) begin
            nm1_d   = q_data_i.nm1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:   state_d = ST_START;
      ST_START: begin
        agree_d = '0;
        held_d  = '0;
        inter_d = '0;
        union_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!soft_busy && !maj_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      agree_q     <= '0;
      held_q      <= '0;
      inter_q     <= '0;
      union_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      agree_q     <= agree_d;
      held_q      <= held_d;
      inter_q     <= inter_d;
      union_q     <= union_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nm1_q <= nm1_d;
    if (state_q == ST_MUL) begin
      den_soft_q <= llos_pkg::SUM_W'(nm1_q) * llos_pkg::SUM_W'(held_q);
    end
    if (div_start) begin
      soft_empty_q <= (held_q == '0);
      maj_empty_q  <= (union_q == '0);
    end
    if (load_out) begin
      soft_ratio_q <= soft_empty_q ? '0 : soft_quo;
      maj_ratio_q  <= maj_empty_q ? '0 : maj_quo;
      soft_flag_q  <= soft_empty_q;
      maj_flag_q   <= maj_empty_q;
    end
  end

  llos_div u_soft_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (agree_q),
    .den_i   (den_soft_q),
    .busy_o  (soft_busy),
    .quo_o   (soft_quo)
  );

  llos_div u_maj_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (llos_pkg::SUM_W'(inter_q)),
    .den_i   (llos_pkg::SUM_W'(union_q)),
    .busy_o  (maj_busy),
    .quo_o   (maj_quo)
  );

  assign res_o.valid          = out_valid_q;
  assign res_o.soft_ratio     = soft_ratio_q;
  assign res_o.majority_ratio = maj_ratio_q;
  assign res_o.soft_empty     = soft_flag_q;
  assign res_o.majority_empty = maj_flag_q;

endmodule

// ===== rtl/leave_one_out_overlap_score_top.sv =====
// Channel   Direction  Transfer on          Payload
// vox_i     in         valid & ready        held_label, agree_count, last_voxel
// res_o     out        valid & ready        soft_ratio, majority_ratio, soft_empty,
//                                           majority_empty
// cfg       in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A voxel is added to the sums as it is popped from the queue; voxels stream at one per cycle
// while the accumulator is in its accumulate state. The last voxel of a volume holds the
// accumulator through a multiply state, a divider start state, 16 Q1.16 divide steps
// and a done check, then the output load. A divider skips its steps when its ratio
// reaches 1.0, and the load waits while an earlier result is still stalled at the output.
// The input stalls only while the two-entry queue is full. Reset clears sums and queue.
module leave_one_out_overlap_score_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  llos_in_if.sink                         vox_i,
  llos_out_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [llos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [llos_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic             q_push, q_pop, q_full, q_empty;
  llos_pkg::voxel_t q_wdata, q_rdata;

  llos_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vox_i       (vox_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  llos_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  llos_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

// ===== rtl/llos_checker.sv =====
module llos_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           valid_i,
  input logic                           ready_i,
  input logic [llos_pkg::RATIO_W-1:0]   soft_ratio_i,
  input logic [llos_pkg::RATIO_W-1:0]   majority_ratio_i,
  input logic                           soft_empty_i,
  input logic                           majority_empty_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && soft_empty_i |-> soft_ratio_i == '0)
    else $error("soft ratio nonzero on empty held set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && majority_empty_i |-> majority_ratio_i == '0)
    else $error("majority ratio nonzero on empty union");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> soft_ratio_i <= llos_pkg::ONE_Q16 && majority_ratio_i <= llos_pkg::ONE_Q16)
    else $error("ratio above 1.0");

endmodule

bind leave_one_out_overlap_score_top llos_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (res_o.valid),
  .ready_i          (res_o.ready),
  .soft_ratio_i     (res_o.soft_ratio),
  .majority_ratio_i (res_o.majority_ratio),
  .soft_empty_i     (res_o.soft_empty),
  .majority_empty_i (res_o.majority_empty)
);

// ===== tb/leave_one_out_overlap_score_top_test.sv =====
module leave_one_out_overlap_score_top_test;
  import llos_pkg::*;

  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_VOXELS = 500;
  localparam int unsigned PLAN_ROWS     = 26;

  typedef enum logic {ROW_VOXEL, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [RATIO_W-1:0] soft_ratio;
    logic [RATIO_W-1:0] majority_ratio;
    logic               soft_empty;
    logic               majority_empty;
  } score_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [AGREE_W-1:0]    agree;
    logic                  last;
    logic                  typed;
    score_t                score;
  } plan_row_t;

  localparam score_t NO_SCORE = '0;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd7, 1'b1, 1'b1, '{ONE_Q16, ONE_Q16, 1'b0, 1'b0}},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0001, 3'd0, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b1, 1'b1}},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd0, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b0, 1'b0}},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0001, 3'd4, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b1, 1'b0}},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hFFFF, 3'd3, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b1, 1'b1}},
    '{ROW_CFG,   REG_ATLAS_COUNT, 16'd2,    3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd7, 1'b1, 1'b1, '{ONE_Q16, ONE_Q16, 1'b0, 1'b0}},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0005, 3'd1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd1, 1'b1, 1'b0, NO_SCORE},
    '{ROW_CFG,   REG_ATLAS_COUNT, 16'd0,    3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CFG,   REG_LABEL_VALUE, 16'hFFFF, 3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hFFFF, 3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hFFFF, 3'd1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h0000, 3'd1, 1'b1, 1'b0, NO_SCORE},
    '{ROW_CFG,   REG_ATLAS_COUNT, 16'd15,   3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hFFFF, 3'd7, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hFFFF, 3'd3, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CFG,   REG_ATLAS_COUNT, 16'd1,    3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hFFFF, 3'd4, 1'b1, 1'b0, NO_SCORE},
    '{ROW_CFG,   REG_ATLAS_COUNT, 16'd5,    3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CFG,   REG_LABEL_VALUE, 16'h5A5A, 3'd0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h5A5A, 3'd2, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'hA5A5, 3'd5, 1'b0, 1'b0, NO_SCORE},
    '{ROW_VOXEL, REG_LABEL_VALUE, 16'h5A5A, 3'd6, 1'b1, 1'b0, NO_SCORE}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  llos_in_if  vox ();
  llos_out_if res ();

  logic [LABEL_W-1:0] label_sel;
  logic [ATLAS_W-1:0] atlas_sel;
  logic [SUM_W-1:0]   agree_acc;
  logic [CNT_W-1:0]   held_cnt;
  logic [CNT_W-1:0]   inter_cnt;
  logic [CNT_W-1:0]   union_cnt;

  score_t      score_q [$];
  bit          idle_on = 1'b1;
  int unsigned errors = 0;
  int unsigned voxels_sent = 0;
  int unsigned scores_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_cnt = 0;

  leave_one_out_overlap_score_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vox_i       (vox),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** leave_one_out_overlap_score_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [RATIO_W-1:0] q16_frac(input longint unsigned num,
                                                  input longint unsigned den);
    if (num >= den) return ONE_Q16;
    return RATIO_W'((num << FRAC_BITS) / den);
  endfunction

  function automatic longint unsigned sat_add(input longint unsigned acc,
                                              input longint unsigned inc,
                                              input int unsigned w);
    longint unsigned cap;
    cap = (64'd1 << w) - 64'd1;
    return (acc + inc > cap) ? cap : acc + inc;
  endfunction

  // Accumulate one voxel; return 1 with the volume score on the last voxel.
  function automatic bit score_voxel(input logic [LABEL_W-1:0] held,
                                     input logic [AGREE_W-1:0] agree,
                                     input logic last, output score_t sc);
    longint unsigned nm1;
    bit              hit;
    bit              major;
    if (atlas_sel < ATLAS_MIN) nm1 = ATLAS_MIN - 1;
    else if (atlas_sel > MAX_ATLASES) nm1 = MAX_ATLASES - 1;
    else nm1 = atlas_sel - 1;
    hit   = (held == label_sel);
    major = (2 * agree) > nm1;
    if (hit) begin
      agree_acc = SUM_W'(sat_add(agree_acc, agree, SUM_W));
      held_cnt  = CNT_W'(sat_add(held_cnt, 1, CNT_W));
    end
    if (hit && major) inter_cnt = CNT_W'(sat_add(inter_cnt, 1, CNT_W));
    if (hit || major) union_cnt = CNT_W'(sat_add(union_cnt, 1, CNT_W));
    sc = '0;
    if (!last) return 1'b0;
    sc.soft_empty     = (held_cnt == 0);
    sc.majority_empty = (union_cnt == 0);
    if (held_cnt != 0) sc.soft_ratio = q16_frac(agree_acc, nm1 * held_cnt);
    if (union_cnt != 0) sc.majority_ratio = q16_frac(inter_cnt, union_cnt);
    agree_acc = '0;
    held_cnt  = '0;
    inter_cnt = '0;
    union_cnt = '0;
    return 1'b1;
  endfunction

  // Drop valid, wait for every pending score, then let the pipeline drain.
  task automatic settle();
    vox.valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_LABEL_VALUE) label_sel = data[LABEL_W-1:0];
    else atlas_sel = data[ATLAS_W-1:0];
    reg_writes++;
  endtask

  task automatic send_voxel(input logic [LABEL_W-1:0] held, input logic [AGREE_W-1:0] agree,
                            input logic last, input logic typed, input score_t typed_score);
    int unsigned gap;
    score_t      sc;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      vox.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vox.valid       <= 1'b1;
    vox.held_label  <= held;
    vox.agree_count <= agree;
    vox.last_voxel  <= last;
    @(posedge clk_i);
    while (vox.ready !== 1'b1) @(posedge clk_i);
    if (score_voxel(held, agree, last, sc)) begin
      score_q.insert(score_q.size(), typed ? typed_score : sc);
    end
    voxels_sent++;
  endtask

  initial begin
    score_t      got;
    score_t      want;
    int unsigned stall;
    res.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (res.valid !== 1'b1) @(posedge clk_i);
      got = '{res.soft_ratio, res.majority_ratio, res.soft_empty, res.majority_empty};
      if (score_q.size() == 0) begin
        $error("score transfer with none expected: soft_ratio %0d majority_ratio %0d",
               got.soft_ratio, got.majority_ratio);
        errors++;
      end else begin
        want = score_q.pop_front();
        scores_seen++;
        if (got.soft_ratio !== want.soft_ratio) begin
          $error("soft_ratio: expected %0d, got %0d", want.soft_ratio, got.soft_ratio);
          errors++;
        end
        if (got.majority_ratio !== want.majority_ratio) begin
          $error("majority_ratio: expected %0d, got %0d",
                 want.majority_ratio, got.majority_ratio);
          errors++;
        end
        if (got.soft_empty !== want.soft_empty) begin
          $error("soft_empty: expected %0d, got %0d", want.soft_empty, got.soft_empty);
          errors++;
        end
        if (got.majority_empty !== want.majority_empty) begin
          $error("majority_empty: expected %0d, got %0d",
                 want.majority_empty, got.majority_empty);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned           vol_left;
    int unsigned           phase_left;
    logic [LABEL_W-1:0]    held;
    logic [LABEL_W-1:0]    lbl;
    logic [CFG_DATA_W-1:0] atl;
    logic                  last;
    rst_ni          = 1'b0;
    vox.valid       = 1'b0;
    vox.held_label  = '0;
    vox.agree_count = '0;
    vox.last_voxel  = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_LABEL_VALUE;
    cfg_wdata       = '0;
    label_sel       = '0;
    atlas_sel       = ATLAS_RESET;
    agree_acc       = '0;
    held_cnt        = '0;
    inter_cnt       = '0;
    union_cnt       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        send_voxel(PLAN[i].value[LABEL_W-1:0], PLAN[i].agree, PLAN[i].last,
                   PLAN[i].typed, PLAN[i].score);
      end
    end

    // Volumes run across phase boundaries, so some see a register change mid-volume.
    vol_left   = $urandom_range(0, 15);
    phase_left = 0;
    repeat (RANDOM_VOXELS) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: lbl = '0;
          1: lbl = '1;
          default: lbl = LABEL_W'($urandom);
        endcase
        atl = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 5))
          0: atl[ATLAS_W-1:0] = '0;
          1: atl[ATLAS_W-1:0] = ATLAS_MIN;
          2: atl[ATLAS_W-1:0] = ATLAS_RESET;
          3: atl[ATLAS_W-1:0] = '1;
          default: ;
        endcase
        write_reg(REG_LABEL_VALUE, lbl);
        write_reg(REG_ATLAS_COUNT, atl);
        idle_on    = ($urandom_range(0, 3) != 0);
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      case ($urandom_range(0, 3))
        0, 1: held = label_sel;
        2: held = label_sel ^ (LABEL_W'(1) << $urandom_range(0, LABEL_W - 1));
        default: held = LABEL_W'($urandom);
      endcase
      last     = (vol_left == 0);
      vol_left = last ? $urandom_range(0, 15) : vol_left - 1;
      send_voxel(held, AGREE_W'($urandom_range(0, 7)), last, 1'b0, NO_SCORE);
    end
    settle();

    $display("Covered %0d voxels, %0d volume scores, %0d register writes.",
             voxels_sent, scores_seen, reg_writes);
    if (errors == 0) begin
      $display("** leave_one_out_overlap_score_top: PASSED **");
    end else begin
      $display("** leave_one_out_overlap_score_top: FAILED **");
    end
    $finish;
  end

endmodule
